[rtl/fnebb_pkg.sv]
// Shared types, constants and helpers of the four-neighbor erosion bounding-box unit.
package fnebb_pkg;

	localparam int COLS_W     = 6;
	localparam int ROWS_W     = 9;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int ROW_OUT_W  = 8;
	localparam int COL_OUT_W  = 5;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;
	localparam int SEA_LIMIT  = 3;

	localparam int DEF_MAX_COLS = 32;
	localparam int DEF_MAX_ROWS = 256;

	localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_COLS = 1'b0,
		REG_IMAGE_ROWS = 1'b1
	} cfg_reg_t;

	// pixel and its three stored neighbors around the read column
	typedef struct packed {
		logic center;
		logic up;
		logic left;
		logic right;
	} nbhd_t;

	// line store write strobe
	typedef struct packed {
		logic en;
		logic pix;
		logic row_end;
	} line_wr_t;

	function automatic int col_w(input int max_cols);
		return (max_cols > 1) ? $clog2(max_cols) : 1;
	endfunction

endpackage

[rtl/fnebb_in_reg.sv]
// Input register stage: holds one incoming pixel until the core takes it.
module fnebb_in_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fnebb_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                           take,
	output logic                           valid_s1,
	output logic                           land_s1
);
	import fnebb_pkg::*;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			land_s1 <= s_tdata[0];
		end
	end

endmodule

[rtl/fnebb_lines.sv]
// Line store: current, previous and second previous image rows, with neighborhood fetch.
module fnebb_lines #(
	parameter int MAX_COLS = fnebb_pkg::DEF_MAX_COLS
) (
	input  logic                                   clk,
	input  fnebb_pkg::line_wr_t                    wr,
	input  logic [fnebb_pkg::col_w(MAX_COLS)-1:0]  col,
	output fnebb_pkg::nbhd_t                       nb
);
	import fnebb_pkg::*;

	localparam int CW = col_w(MAX_COLS);

	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] prev1_q;
	logic [MAX_COLS-1:0] prev2_q;
	logic [MAX_COLS-1:0] row_w;
	logic [CW-1:0]       lidx;
	logic [CW-1:0]       ridx;

	always_comb begin
		row_w      = cur_q;
		row_w[col] = wr.pix;
	end

	// edge columns are masked by the core; keep indexes in range
	assign lidx = (col == '0) ? col : col - CW'(1);
	assign ridx = (col == CW'(MAX_COLS - 1)) ? col : col + CW'(1);

	assign nb.center = prev1_q[col];
	assign nb.up     = prev2_q[col];
	assign nb.left   = prev1_q[lidx];
	assign nb.right  = prev1_q[ridx];

	// on the last pixel of a row, advance the finished row into the window
	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.row_end) begin
				prev2_q <= prev1_q;
				prev1_q <= row_w;
			end else begin
				cur_q <= row_w;
			end
		end
	end

endmodule

[rtl/fnebb_core.sv]
// Core: raster counters, frame flush sequencer, erosion, bounding box and result register.
module fnebb_core #(
	parameter int MAX_COLS = fnebb_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = fnebb_pkg::DEF_MAX_ROWS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wen,
	input  logic [fnebb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fnebb_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                   valid_s1,
	input  logic                                   land_s1,
	output logic                                   take,
	output logic [fnebb_pkg::col_w(MAX_COLS)-1:0]  col,
	input  fnebb_pkg::nbhd_t                       nb,
	output fnebb_pkg::line_wr_t                    wr,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [fnebb_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                   m_tlast,
	output logic [0:0]                             m_tuser
);
	import fnebb_pkg::*;

	localparam int CW  = col_w(MAX_COLS);
	localparam int CN  = COLS_W + 1;
	localparam int RN  = ROWS_W + 1;

	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] eff_cols;
	logic [ROWS_W-1:0] eff_rows;

	logic [ROWS_W-1:0] r_q;
	logic [CW-1:0]     c_q;
	logic [CW-1:0]     k_q;
	logic              flush_q;

	logic              seen_q;
	logic [ROWS_W-1:0] top_q;
	logic [ROWS_W-1:0] bot_q;
	logic [CW-1:0]     lft_q;
	logic [CW-1:0]     rgt_q;

	logic              seen_n;
	logic [ROWS_W-1:0] top_n;
	logic [ROWS_W-1:0] bot_n;
	logic [CW-1:0]     lft_n;
	logic [CW-1:0]     rgt_n;

	logic                 out_valid_q;
	logic                 out_land_q;
	logic [ROW_OUT_W-1:0] out_row_q;
	logic [COL_OUT_W-1:0] out_col_q;
	logic                 out_last_q;
	logic                 out_empty_q;
	logic [ROW_OUT_W-1:0] out_top_q;
	logic [ROW_OUT_W-1:0] out_bottom_q;
	logic [COL_OUT_W-1:0] out_left_q;
	logic [COL_OUT_W-1:0] out_right_q;

	logic              last_col;
	logic              last_row;
	logic              final_px;
	logic              flush_last;
	logic              out_free;
	logic              flush_go;
	logic              need_out;
	logic              emit;
	logic              frame_last;
	logic [ROWS_W-1:0] erow;
	logic              top_edge;
	logic              left_edge;
	logic              right_edge;
	logic              down;
	logic [2:0]        sea;
	logic              keep;

	// zero means one; saturate at the build limits
	always_comb begin
		if (cols_q == '0) begin
			eff_cols = COLS_W'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			eff_cols = COLS_W'(MAX_COLS);
		end else begin
			eff_cols = cols_q;
		end
		if (rows_q == '0) begin
			eff_rows = ROWS_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			eff_rows = ROWS_W'(MAX_ROWS);
		end else begin
			eff_rows = rows_q;
		end
	end

	assign last_col   = (CN'(c_q) + CN'(1)) == CN'(eff_cols);
	assign last_row   = (RN'(r_q) + RN'(1)) == RN'(eff_rows);
	assign final_px   = last_row && last_col;
	assign flush_last = (CN'(k_q) + CN'(1)) == CN'(eff_cols);

	assign out_free   = !out_valid_q || m_tready;
	assign flush_go   = flush_q && out_free;
	assign need_out   = (r_q != '0);
	assign take       = valid_s1 && !flush_q && (!need_out || out_free);
	assign emit       = flush_go || (take && need_out);
	assign frame_last = flush_q && flush_last;

	// normal items emit the row above; the flush walks the final row
	assign col        = flush_q ? k_q : c_q;
	assign erow       = flush_q ? r_q : r_q - ROWS_W'(1);
	assign top_edge   = (erow == '0);
	assign down       = flush_q ? 1'b0 : land_s1;
	assign left_edge  = (col == '0);
	assign right_edge = (CN'(col) + CN'(1)) >= CN'(eff_cols);

	assign sea  = 3'(top_edge || !nb.up) + 3'(!down) + 3'(left_edge || !nb.left)
		+ 3'(right_edge || !nb.right);
	assign keep = nb.center && (int'(sea) < SEA_LIMIT);

	assign wr.en      = take;
	assign wr.pix     = land_s1;
	assign wr.row_end = last_col;

	always_comb begin
		seen_n = seen_q;
		top_n  = top_q;
		bot_n  = bot_q;
		lft_n  = lft_q;
		rgt_n  = rgt_q;
		if (emit && keep) begin
			seen_n = 1'b1;
			if (!seen_q) begin
				top_n = erow;
				bot_n = erow;
				lft_n = col;
				rgt_n = col;
			end else begin
				if (erow < top_q) top_n = erow;
				if (erow > bot_q) bot_n = erow;
				if (col < lft_q) lft_n = col;
				if (col > rgt_q) rgt_n = col;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= COLS_RESET;
			rows_q      <= ROWS_RESET;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			flush_q     <= 1'b0;
			seen_q      <= 1'b0;
			top_q       <= '0;
			bot_q       <= '0;
			lft_q       <= '0;
			rgt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_COLS: cols_q <= cfg_wdata[COLS_W-1:0];
					REG_IMAGE_ROWS: rows_q <= cfg_wdata[ROWS_W-1:0];
					default: ;
				endcase
				// restart the frame; the line store is kept
				r_q     <= '0;
				c_q     <= '0;
				k_q     <= '0;
				flush_q <= 1'b0;
				seen_q  <= 1'b0;
				top_q   <= '0;
				bot_q   <= '0;
				lft_q   <= '0;
				rgt_q   <= '0;
			end else begin
				// the frame end clears the box below instead
				if (emit && !frame_last) begin
					seen_q <= seen_n;
					top_q  <= top_n;
					bot_q  <= bot_n;
					lft_q  <= lft_n;
					rgt_q  <= rgt_n;
				end
				if (take) begin
					if (final_px) begin
						flush_q <= 1'b1;
						k_q     <= '0;
					end else if (last_col) begin
						c_q <= '0;
						r_q <= r_q + ROWS_W'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				if (flush_go) begin
					if (flush_last) begin
						flush_q <= 1'b0;
						r_q     <= '0;
						c_q     <= '0;
						seen_q  <= 1'b0;
						top_q   <= '0;
						bot_q   <= '0;
						lft_q   <= '0;
						rgt_q   <= '0;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_land_q  <= keep;
			out_row_q   <= ROW_OUT_W'(erow);
			out_col_q   <= COL_OUT_W'(col);
			out_last_q  <= frame_last;
			out_empty_q <= frame_last && !seen_n;
			if (frame_last && seen_n) begin
				out_top_q    <= ROW_OUT_W'(top_n);
				out_bottom_q <= ROW_OUT_W'(bot_n);
				out_left_q   <= COL_OUT_W'(lft_n);
				out_right_q  <= COL_OUT_W'(rgt_n);
			end else begin
				out_top_q    <= '0;
				out_bottom_q <= '0;
				out_left_q   <= '0;
				out_right_q  <= '0;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {out_right_q, out_left_q, out_bottom_q, out_top_q,
		out_col_q, out_row_q, out_land_q};
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_empty_q;

endmodule

[rtl/four_neighbour_erosion_bbox_unit.sv]
// Top level of the four-neighbor binary erosion unit with bounding box.
//
//  channel   dir  payload                                       handshake
//  s_*       in   tdata[0] land_in                              tvalid/tready
//  m_*       out  tdata land_out..box_right, tlast, tuser       tvalid/tready
//  cfg_*     in   cfg_index, cfg_wdata                          cfg_wen
//
// One pixel item per cycle while the output is not stalled and no flush runs; a result
// passes the input register and then the result register before it reaches m_*.
// The last pixel of a frame starts a flush that emits the final row, one item per column;
// input is held off during it, set by the single flush sequencer in the core.
// Reset clears counters, box, flush state and the output valid; the line store is not reset.
// A stalled output holds its item; the input register keeps accepting while it has room.
module four_neighbour_erosion_bbox_unit #(
	parameter int MAX_COLS = fnebb_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = fnebb_pkg::DEF_MAX_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fnebb_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] land_in, rest zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] land_out, [8:1] pix_row, [13:9] pix_col, [21:14] box_top,
	// [29:22] box_bottom, [34:30] box_left, [39:35] box_right
	output logic [fnebb_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                             m_tlast,   // frame_end
	output logic [0:0]                       m_tuser,   // [0] box_empty
	input  logic                             cfg_wen,
	input  logic [fnebb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fnebb_pkg::CFG_W-1:0]      cfg_wdata
);
	import fnebb_pkg::*;

	localparam int CW = col_w(MAX_COLS);

	logic          take;
	logic          valid_s1;
	logic          land_s1;
	logic [CW-1:0] col;
	nbhd_t         nb;
	line_wr_t      wr;

	fnebb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.land_s1  (land_s1)
	);

	fnebb_lines #(
		.MAX_COLS (MAX_COLS)
	) u_lines (
		.clk (clk),
		.wr  (wr),
		.col (col),
		.nb  (nb)
	);

	fnebb_core #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.land_s1   (land_s1),
		.take      (take),
		.col       (col),
		.nb        (nb),
		.wr        (wr),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

[rtl/fnebb_checker.sv]
// Port-level checks of the erosion unit's result stream, bound to the top level.
module fnebb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [fnebb_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                             m_tlast,
	input logic [0:0]                       m_tuser
);
	import fnebb_pkg::*;

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result item changed while stalled");

	// box fields and empty flag only on the frame end
	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == 1'b0 && m_tdata[39:14] == '0)
		else $error("box data on a result that is not frame end");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser[0] |-> m_tdata[39:14] == '0)
		else $error("empty frame carries a nonzero box");

	// the frame end is the rightmost column, so it bounds the box on the right
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser[0] |-> m_tdata[21:14] <= m_tdata[29:22]
			&& m_tdata[34:30] <= m_tdata[39:35] && m_tdata[39:35] <= m_tdata[13:9])
		else $error("bounding box out of order");

endmodule

bind four_neighbour_erosion_bbox_unit fnebb_checker u_fnebb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
